@@ src/ordered_set_successor_unit_macros.svh @@
// ----------------------------------------------------------------------------
// ordered set successor unit assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ORDERED_SET_SUCCESSOR_UNIT_MACROS_SVH
`define ORDERED_SET_SUCCESSOR_UNIT_MACROS_SVH

// same-cycle implication
`define OSS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/oss_pkg.sv @@
// ----------------------------------------------------------------------------
// oss_pkg
// shared constants, codes and types of the ordered set successor unit
// ----------------------------------------------------------------------------
package oss_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int KEY_FIELD_W   = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_ANSWERED  = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_CMP  = 3'b010,
        FSM_RES  = 3'b100
    } fsm_t;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

@@ src/oss_cell.sv @@
// ----------------------------------------------------------------------------
// oss_cell
// one slot of the sorted key chain: holds a key, compares it against the
// broadcast key and shifts right or captures the new key on insert
// ----------------------------------------------------------------------------
module oss_cell #(
    parameter int KEY_WIDTH = oss_pkg::KEY_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  oss_pkg::cell_ctrl_t    ctrl,
    input  logic [KEY_WIDTH-1:0]   key_in,
    input  logic [KEY_WIDTH-1:0]   left_key,
    input  logic                   left_valid,
    input  logic                   left_ge,
    output logic [KEY_WIDTH-1:0]   key_out,
    output logic                   valid_out,
    output logic                   ge_out,
    output logic                   eq_out
);
    import oss_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 ge_reg;
    logic                 eq_reg;
    logic                 ge_now;
    logic                 eq_now;

    // empty slots sort above every key
    assign ge_now = !valid_reg || (key_reg >= key_in);
    assign eq_now = valid_reg && (key_reg == key_in);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.shift_en)
        begin
            if (left_ge)
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
            else if (ge_reg)
            begin
                key_next   = key_in;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp_en)
            begin
                ge_reg <= ge_now;
                eq_reg <= eq_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign ge_out    = ge_reg;
    assign eq_out    = eq_reg;

endmodule

@@ src/ordered_set_successor_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_set_successor_unit
// bounded ordered set of distinct keys with insert and successor query
// ----------------------------------------------------------------------------
// a command beat is taken at a rising edge with start high and busy low:
// command selects insert or query, key_value carries the key or the search
// value. the keys live in a chain of CAPACITY cells, kept sorted, valid
// cells forming a prefix. in the compare state every cell compares its key
// against the broadcast key; in the result state the flags are combined into the
// duplicate, full and successor answers and an insert shifts the upper
// cells one place right while the gap cell captures the new key.
// the result beat shows on strobe, status, found and result_key for one
// cycle; its fields are registered from the result state.
// busy stays high through the compare and result states, so a new command is
// taken only once the unit is idle again; the spacing is set by the compare
// state and the combine and shift state of the cell chain.
// the receiver cannot stall; each beat must be taken when strobe is high.
// reset empties the set at once and leaves the unit idle.
// ----------------------------------------------------------------------------
module ordered_set_successor_unit #(
    parameter int CAPACITY  = oss_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = oss_pkg::KEY_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic [oss_pkg::KEY_FIELD_W-1:0]  key_value,
    output logic                             strobe,
    output logic [oss_pkg::STATUS_W-1:0]     status,
    output logic                             found,
    output logic [oss_pkg::KEY_FIELD_W-1:0]  result_key
);
    import oss_pkg::*;
    `include "ordered_set_successor_unit_macros.svh"

    fsm_t                   state_reg;
    fsm_t                   state_next;
    logic                   cmd_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_in;
    cell_ctrl_t             ctrl;
    logic                   accept;

    logic [KEY_WIDTH-1:0]   cell_key [CAPACITY];
    logic [CAPACITY-1:0]    valid_vec;
    logic [CAPACITY-1:0]    ge_vec;
    logic [CAPACITY-1:0]    eq_vec;
    logic [CAPACITY-1:0]    first_vec;

    logic                   dup;
    logic                   full;
    logic                   hit;
    logic [KEY_WIDTH-1:0]   hit_key;
    logic [KEY_FIELD_W-1:0] hit_key_field;

    logic                   strobe_reg;
    status_t                status_reg;
    status_t                status_next;
    logic                   found_reg;
    logic [KEY_FIELD_W-1:0] result_key_reg;

    assign accept = start && (state_reg == FSM_IDLE);
    assign busy   = (state_reg != FSM_IDLE);

    generate
        if (KEY_WIDTH == KEY_FIELD_W)
        begin : g_key_same
            assign key_in        = key_value;
            assign hit_key_field = hit_key;
        end
        else if (KEY_WIDTH < KEY_FIELD_W)
        begin : g_key_narrow
            assign key_in        = key_value[KEY_WIDTH-1:0];
            assign hit_key_field = {{(KEY_FIELD_W-KEY_WIDTH){1'b0}}, hit_key};
        end
        else
        begin : g_key_wide
            assign key_in        = {{(KEY_WIDTH-KEY_FIELD_W){1'b0}}, key_value};
            assign hit_key_field = hit_key[KEY_FIELD_W-1:0];
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (start) state_next = FSM_CMP;
            FSM_CMP:  state_next = FSM_RES;
            FSM_RES:  state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == FSM_RES);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= key_in;
        end
    end

    // combine the cell flags; ge is monotone along the chain
    always_comb
    begin
        hit_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                first_vec[i] = ge_vec[i] & valid_vec[i];
            else
                first_vec[i] = ge_vec[i] & ~ge_vec[i-1] & valid_vec[i];
            hit_key = hit_key | (cell_key[i] & {KEY_WIDTH{first_vec[i]}});
        end
    end

    assign dup  = |eq_vec;
    assign full = valid_vec[CAPACITY-1];
    assign hit  = |first_vec;

    assign ctrl.cmp_en   = (state_reg == FSM_CMP);
    assign ctrl.shift_en = (state_reg == FSM_RES) && (cmd_reg == CMD_INSERT) && !dup && !full;

    always_comb
    begin
        if (cmd_reg == CMD_QUERY)
            status_next = ST_ANSWERED;
        else if (dup)
            status_next = ST_DUPLICATE;
        else if (full)
            status_next = ST_FULL;
        else
            status_next = ST_INSERTED;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_RES)
        begin
            status_reg     <= status_next;
            found_reg      <= (cmd_reg == CMD_QUERY) && hit;
            result_key_reg <= (cmd_reg == CMD_QUERY) ? hit_key_field : '0;
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] left_key;
            logic                 left_valid;
            logic                 left_ge;
            if (i == 0)
            begin : g_head
                assign left_key   = '0;
                assign left_valid = 1'b0;
                assign left_ge    = 1'b0;
            end
            else
            begin : g_body
                assign left_key   = cell_key[i-1];
                assign left_valid = valid_vec[i-1];
                assign left_ge    = ge_vec[i-1];
            end
            oss_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key_in     (key_reg),
                .left_key   (left_key),
                .left_valid (left_valid),
                .left_ge    (left_ge),
                .key_out    (cell_key[i]),
                .valid_out  (valid_vec[i]),
                .ge_out     (ge_vec[i]),
                .eq_out     (eq_vec[i])
            );
        end
    endgenerate

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign result_key = result_key_reg;

    `OSS_ASSERT_NEXT(a_accept_to_cmp, accept, state_reg == FSM_CMP, "command not compared")
    `OSS_ASSERT_NEXT(a_res_to_strobe, state_reg == FSM_RES, strobe, "result beat missing")
    `OSS_ASSERT_IMP(a_insert_fields_zero, strobe && (status != ST_ANSWERED),
        !found && (result_key == '0), "insert beat carries query fields")
    `OSS_ASSERT_IMP(a_valid_prefix, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0,
        "valid cells not a prefix")

endmodule
